@@ hdl/htit_pkg.sv @@
`timescale 1ns / 1ps

package htit_pkg;

    localparam int KEY_W     = 64;
    localparam int HANDLER_W = 64;
    localparam int QIDX_W    = 10;
    localparam int FIDX_W    = 8;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_CHECK  = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_INVALID   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_DONE
    } state_t;

endpackage

@@ hdl/hash_to_index_register_table.sv @@
`timescale 1ns / 1ps

// flow: index check, unused action codes and insert into a full table go from idle straight
// to the done state; other inserts and lookups scan first, and a lookup hit fetches the handler
// throughput: one item at a time, set by the sequential key scan (one stored key compared
// per cycle through the single read port of the key memory); the next beat can be taken
// as soon as the output valid rises, while a finished result may wait in the output register
// reset: rst_n clears the fill count, the sequencer and the output valid at once;
// key and handler memories are not cleared and only filled entries are ever read
module hash_to_index_register_table #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       action,
    input  logic [htit_pkg::KEY_W-1:0]       key_hash,
    input  logic [htit_pkg::HANDLER_W-1:0]   handler_word,
    input  logic [htit_pkg::QIDX_W-1:0]      query_index,
    input  logic                             batch_last,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic [htit_pkg::FIDX_W-1:0]      found_index,
    output logic [htit_pkg::HANDLER_W-1:0]   found_handler,
    output logic                             batch_done
);
    import htit_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > QIDX_W) ? CNT_W : QIDX_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    logic [KEY_W-1:0]     key_mem     [TABLE_ENTRIES];
    logic [HANDLER_W-1:0] handler_mem [TABLE_ENTRIES];

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0] match_idx_reg, match_idx_next;
    logic             out_valid_reg, out_valid_next;

    logic [1:0]           act_reg, act_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [HANDLER_W-1:0] handler_reg, handler_next;

    logic [1:0]        res_status_reg, res_status_next;
    logic [FIDX_W-1:0] res_index_reg, res_index_next;
    logic              res_hit_reg, res_hit_next;
    logic              res_done_reg, res_done_next;

    logic [1:0]           status_reg, status_next;
    logic [FIDX_W-1:0]    found_index_reg, found_index_next;
    logic [HANDLER_W-1:0] found_handler_reg, found_handler_next;
    logic                 batch_done_reg, batch_done_next;

    logic [KEY_W-1:0]     key_rd_reg;
    logic [HANDLER_W-1:0] handler_rd_reg;

    logic             key_re, handler_re, mem_we;
    logic [IDX_W-1:0] key_raddr;

    logic             in_fire, out_free, hit, can_issue, scan_miss;
    logic [CMP_W-1:0] qidx_ext, count_ext;
    logic [IDX_W+FIDX_W-1:0] pend_idx_wide;

    assign in_ready      = (state_reg == ST_IDLE);
    assign in_fire       = in_valid && in_ready;
    assign out_free      = !out_valid_reg || out_ready;
    assign hit           = pend_reg && (key_rd_reg == key_reg);
    assign can_issue     = (issue_reg < count_reg);
    assign scan_miss     = !hit && !can_issue && !pend_reg;
    assign qidx_ext      = CMP_W'(query_index);
    assign count_ext     = CMP_W'(count_reg);
    assign pend_idx_wide = {{FIDX_W{1'b0}}, pend_idx_reg};
    assign key_raddr     = issue_reg[IDX_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if ((action == ACT_INSERT && count_reg != FULL_COUNT) ||
                        action == ACT_LOOKUP)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                    state_next = (act_reg == ACT_LOOKUP) ? ST_FETCH : ST_DONE;
                else if (scan_miss)
                    state_next = ST_DONE;
            end
            ST_FETCH:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next         = count_reg;
        issue_next         = issue_reg;
        pend_next          = pend_reg;
        pend_idx_next      = pend_idx_reg;
        match_idx_next     = match_idx_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        act_next           = act_reg;
        key_next           = key_reg;
        handler_next       = handler_reg;
        res_status_next    = res_status_reg;
        res_index_next     = res_index_reg;
        res_hit_next       = res_hit_reg;
        res_done_next      = res_done_reg;
        status_next        = status_reg;
        found_index_next   = found_index_reg;
        found_handler_next = found_handler_reg;
        batch_done_next    = batch_done_reg;
        key_re             = 1'b0;
        handler_re         = 1'b0;
        mem_we             = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    act_next        = action;
                    key_next        = key_hash;
                    handler_next    = handler_word;
                    issue_next      = '0;
                    pend_next       = 1'b0;
                    res_status_next = STAT_OK;
                    res_index_next  = '0;
                    res_hit_next    = 1'b0;
                    res_done_next   = 1'b0;
                    case (action)
                        ACT_INSERT:
                        begin
                            res_done_next = batch_last;
                            if (count_reg == FULL_COUNT)
                                res_status_next = STAT_FULL;
                        end
                        ACT_LOOKUP:
                            res_status_next = STAT_OK;
                        ACT_CHECK:
                        begin
                            if (qidx_ext >= count_ext)
                                res_status_next = STAT_INVALID;
                        end
                        default:
                            res_status_next = STAT_INVALID;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    pend_next = 1'b0;
                    if (act_reg == ACT_LOOKUP)
                    begin
                        match_idx_next = pend_idx_reg;
                        res_index_next = pend_idx_wide[FIDX_W-1:0];
                        res_hit_next   = 1'b1;
                    end
                end
                else if (can_issue)
                begin
                    key_re        = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                    issue_next    = issue_reg + 1'b1;
                end
                else if (pend_reg)
                    pend_next = 1'b0;
                else if (act_reg == ACT_INSERT)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                else
                    res_status_next = STAT_NOT_FOUND;
            end
            ST_FETCH:
                handler_re = 1'b1;
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    status_next        = res_status_reg;
                    found_index_next   = res_index_reg;
                    found_handler_next = res_hit_reg ? handler_rd_reg : '0;
                    batch_done_next    = res_done_reg;
                end
            end
            default:
                out_valid_next = out_valid_reg && !out_ready;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg      <= pend_idx_next;
        match_idx_reg     <= match_idx_next;
        act_reg           <= act_next;
        key_reg           <= key_next;
        handler_reg       <= handler_next;
        res_status_reg    <= res_status_next;
        res_index_reg     <= res_index_next;
        res_hit_reg       <= res_hit_next;
        res_done_reg      <= res_done_next;
        status_reg        <= status_next;
        found_index_reg   <= found_index_next;
        found_handler_reg <= found_handler_next;
        batch_done_reg    <= batch_done_next;
    end

    // key and handler memories
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[count_reg[IDX_W-1:0]]     <= key_reg;
            handler_mem[count_reg[IDX_W-1:0]] <= handler_reg;
        end
        if (key_re)
            key_rd_reg <= key_mem[key_raddr];
        if (handler_re)
            handler_rd_reg <= handler_mem[match_idx_reg];
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign found_index   = found_index_reg;
    assign found_handler = found_handler_reg;
    assign batch_done    = batch_done_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("fill count above table size");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ($past(state_reg) == ST_SCAN && count_reg == $past(count_reg) + 1'b1))
        else $error("fill count changed outside an insert");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("output beat raised outside done state");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == STAT_FULL) |-> (count_reg == FULL_COUNT))
        else $error("full status with free entries");

endmodule
